// ===== hdl/qxm_pkg.sv =====
`default_nettype none

package qxm_pkg;

  // Fixed-point format
  localparam int FRAC_BITS = 16;
  localparam int ONE_Q     = 1 << FRAC_BITS;
  localparam int YAW_EPS   = ONE_Q / 1000;

  // Field widths
  localparam int CFG_W     = FRAC_BITS + 1;        // max, headroom, idle, data port
  localparam int GAIN_W    = 16;
  localparam int THR_W     = CFG_W + 1;
  localparam int CMD_W     = 16;
  localparam int MOT_W     = CFG_W;
  localparam int CFG_IDX_W = 2;

  // Internal widths
  localparam int PROD_W  = CMD_W + GAIN_W + 1;     // command * gain
  localparam int YC_W    = CFG_W + 1;              // yaw clamped to +-max
  localparam int YH_W    = YC_W + CFG_W + 1;       // clamped yaw * headroom
  localparam int YAW_W   = YH_W - FRAC_BITS;       // headroom-scaled yaw
  localparam int A_W     = YAW_W;                  // yaw magnitude, divisor
  localparam int MIX_W   = 38;                     // motor mix sums
  localparam int SCALE_W = FRAC_BITS + 1;
  localparam int SP_W    = YAW_W + SCALE_W + 1;    // yaw * scale
  localparam int YS_W    = SP_W - FRAC_BITS;

  // Stream packing
  localparam int ROLL_LSB    = THR_W;
  localparam int PITCH_LSB   = THR_W + CMD_W;
  localparam int YAW_LSB     = THR_W + 2 * CMD_W;
  localparam int IN_BITS     = THR_W + 3 * CMD_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 4 * MOT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD     = OUT_TDATA_W - OUT_BITS;

  // Quad-X sign table, bit i set means the axis is subtracted for motor i
  // (0 front left, 1 front right, 2 rear left, 3 rear right)
  localparam logic [3:0] ROLL_NEG  = 4'b1010;
  localparam logic [3:0] PITCH_NEG = 4'b1100;
  localparam logic [3:0] YAW_NEG   = 4'b1001;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_THROTTLE  = 2'd0,
    REG_AXIS_GAIN     = 2'd1,
    REG_YAW_HEADROOM  = 2'd2,
    REG_IDLE_THROTTLE = 2'd3
  } cfg_reg_t;

  typedef logic signed [MIX_W-1:0] mix_t;
  typedef mix_t [3:0] mix4_t;

  // Payload that rides alongside the yaw scale division
  typedef struct packed {
    mix4_t                   mix;
    logic signed [YAW_W-1:0] yaw;
    logic                    over;
    logic                    do_div;
  } div_side_t;

endpackage

`default_nettype wire

// ===== hdl/qxm_divider.sv =====
`default_nettype none

// Pipelined restoring divider: one quotient bit per stage, num < den assumed,
// quotient = floor((num << FRAC_BITS) / den).
module qxm_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [qxm_pkg::A_W-1:0]        num,
  input  logic [qxm_pkg::A_W-1:0]        den,
  input  qxm_pkg::div_side_t             in_side,
  output logic                           out_valid,
  output logic [qxm_pkg::FRAC_BITS-1:0]  quot,
  output qxm_pkg::div_side_t             out_side
);
  import qxm_pkg::*;

  localparam int REM_W = A_W + 1;

  logic                 vld  [FRAC_BITS];
  logic [REM_W-1:0]     rem  [FRAC_BITS];
  logic [A_W-1:0]       dvs  [FRAC_BITS];
  logic [FRAC_BITS-1:0] quo  [FRAC_BITS];
  div_side_t            side [FRAC_BITS];

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_step
    logic                 vld_in;
    logic [REM_W-1:0]     rem_in;
    logic [A_W-1:0]       dvs_in;
    logic [FRAC_BITS-1:0] quo_in;
    div_side_t            side_in;
    logic [REM_W-1:0]     rem_sh;
    logic                 ge;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = {1'b0, num};
      assign dvs_in  = den;
      assign quo_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld[k-1];
      assign rem_in  = rem[k-1];
      assign dvs_in  = dvs[k-1];
      assign quo_in  = quo[k-1];
      assign side_in = side[k-1];
    end

    // shift in a zero, subtract the divisor when it fits
    assign rem_sh = {rem_in[REM_W-2:0], 1'b0};
    assign ge     = rem_sh >= {1'b0, dvs_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? (rem_sh - {1'b0, dvs_in}) : rem_sh;
        dvs[k]  <= dvs_in;
        quo[k]  <= {quo_in[FRAC_BITS-2:0], ge};
        side[k] <= side_in;
      end
    end
  end

  assign out_valid = vld[FRAC_BITS-1];
  assign quot      = quo[FRAC_BITS-1];
  assign out_side  = side[FRAC_BITS-1];

endmodule

`default_nettype wire

// ===== hdl/quad_x_motor_mixer_core.sv =====
// Quad-X motor mixer with airmode.
// Slave stream s_axis takes one item per transfer: throttle and the roll,
// pitch and yaw controller outputs. Master stream m_axis gives one result
// per item: four motor commands in tdata and the yaw-limited flag in tuser.
// Configuration registers (max_throttle, axis_gain, yaw_headroom,
// idle_throttle at index 0..3) are written over cfg_valid/cfg_index/cfg_data;
// cfg_ready is always high. Write them only while no item is in flight.
// The path from the input transfer to m_axis_tvalid runs through seven mix
// stages, a 16-stage divider (one quotient bit per stage) for the yaw scale,
// three output stages and the output register. It takes one item per
// cycle while s_axis_tready is high; the pipeline has no loop.
// When the receiver stalls, the output register holds its result and a skid
// register catches the one item that was already moving, after which
// s_axis_tready drops until the skid empties. Nothing is lost or repeated.
// Reset (rst, synchronous) empties the pipeline and restores the register
// defaults: full-scale max, gain 164, headroom one, idle zero.
`default_nettype none

module quad_x_motor_mixer_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // throttle[17:0], roll_cmd[33:18], pitch_cmd[49:34], yaw_cmd[65:50], zero pad
  input  logic [qxm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // motor_front_left[16:0], motor_front_right[33:17], motor_rear_left[50:34],
  // motor_rear_right[67:51], zero pad
  output logic [qxm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // yaw_limited
  output logic                                m_axis_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qxm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qxm_pkg::CFG_W-1:0]           cfg_data
);
  import qxm_pkg::*;

  function automatic mix_t max2(mix_t x, mix_t y);
    return (x > y) ? x : y;
  endfunction

  function automatic mix_t min2(mix_t x, mix_t y);
    return (x < y) ? x : y;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers
  logic [CFG_W-1:0]  max_throttle;
  logic [GAIN_W-1:0] axis_gain;
  logic [CFG_W-1:0]  yaw_headroom;
  logic [CFG_W-1:0]  idle_throttle;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_throttle  <= CFG_W'(ONE_Q);
      axis_gain     <= GAIN_W'(164);
      yaw_headroom  <= CFG_W'(ONE_Q);
      idle_throttle <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAX_THROTTLE:  max_throttle  <= cfg_data;
        REG_AXIS_GAIN:     axis_gain     <= cfg_data[GAIN_W-1:0];
        REG_YAW_HEADROOM:  yaw_headroom  <= cfg_data;
        REG_IDLE_THROTTLE: idle_throttle <= cfg_data;
        default: ;
      endcase
    end
  end

  mix_t mx_mix;
  assign mx_mix = mix_t'({1'b0, max_throttle});

  // Pipeline advance: frozen only while the skid register is occupied
  logic en;
  logic skid_valid;
  assign en            = !skid_valid;
  assign s_axis_tready = en;

  // ---------------------------------------------------------------------
  // Stage 1: throttle clamp, axis gain multiplies
  logic signed [THR_W-1:0] thr_in;
  logic signed [CMD_W-1:0] roll_in, pitch_in, yaw_in;
  logic signed [GAIN_W:0]  gain_s;
  logic [CFG_W-1:0]        thr_clamp;

  assign thr_in   = s_axis_tdata[THR_W-1:0];
  assign roll_in  = s_axis_tdata[ROLL_LSB +: CMD_W];
  assign pitch_in = s_axis_tdata[PITCH_LSB +: CMD_W];
  assign yaw_in   = s_axis_tdata[YAW_LSB +: CMD_W];
  assign gain_s   = {1'b0, axis_gain};

  always_comb begin
    if (thr_in[THR_W-1]) begin
      thr_clamp = '0;
    end else if (thr_in > {1'b0, max_throttle}) begin
      thr_clamp = max_throttle;
    end else begin
      thr_clamp = thr_in[CFG_W-1:0];
    end
  end

  logic                     v1;
  logic [CFG_W-1:0]         t1;
  logic signed [PROD_W-1:0] r1, p1, yp1;

  always_ff @(posedge clk) begin
    if (en) begin
      t1  <= thr_clamp;
      r1  <= roll_in * gain_s;
      p1  <= pitch_in * gain_s;
      yp1 <= yaw_in * gain_s;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: yaw clamp and headroom multiply, roll/pitch mix
  logic signed [PROD_W-1:0] mx_prod;
  logic signed [YC_W-1:0]   mx_yc;
  logic signed [YC_W-1:0]   yc;
  logic signed [CFG_W:0]    hr_s;
  mix4_t                    mix_c2;

  assign mx_prod = {{(PROD_W-CFG_W){1'b0}}, max_throttle};
  assign mx_yc   = {1'b0, max_throttle};
  assign hr_s    = {1'b0, yaw_headroom};

  always_comb begin
    if (yp1 > mx_prod) begin
      yc = mx_yc;
    end else if (yp1 < -mx_prod) begin
      yc = -mx_yc;
    end else begin
      yc = yp1[YC_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mix_c2[i] = mix_t'(t1)
                + (ROLL_NEG[i]  ? -mix_t'(r1) : mix_t'(r1))
                + (PITCH_NEG[i] ? -mix_t'(p1) : mix_t'(p1));
    end
  end

  logic                   v2;
  logic signed [YH_W-1:0] yh2;
  mix4_t                  m2;

  always_ff @(posedge clk) begin
    if (en) begin
      yh2 <= yc * hr_s;
      m2  <= mix_c2;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: yaw truncation toward zero, highest and lowest motor
  logic signed [YH_W-1:0] yh_adj;
  assign yh_adj = yh2 + (yh2[YH_W-1] ? YH_W'(ONE_Q - 1) : YH_W'(0));

  logic                    v3;
  logic signed [YAW_W-1:0] y3;
  mix4_t                   m3;
  mix_t                    hi3, lo3;

  always_ff @(posedge clk) begin
    if (en) begin
      y3  <= yh_adj[YH_W-1:FRAC_BITS];
      m3  <= m2;
      hi3 <= max2(max2(m2[0], m2[1]), max2(m2[2], m2[3]));
      lo3 <= min2(min2(m2[0], m2[1]), min2(m2[2], m2[3]));
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: shift down past max, shift up out of negative (airmode)
  mix_t  shift4;
  mix4_t mix_c4;

  always_comb begin
    shift4 = ((hi3 > mx_mix) ? (hi3 - mx_mix) : mix_t'(0))
           + (lo3[MIX_W-1] ? lo3 : mix_t'(0));
    for (int i = 0; i < 4; i++) begin
      mix_c4[i] = m3[i] - shift4;
    end
  end

  logic                    v4;
  logic signed [YAW_W-1:0] y4;
  mix4_t                   m4;

  always_ff @(posedge clk) begin
    if (en) begin
      y4 <= y3;
      m4 <= mix_c4;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: motor plus full yaw
  mix4_t sum_c5;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum_c5[i] = m4[i] + (YAW_NEG[i] ? -mix_t'(y4) : mix_t'(y4));
    end
  end

  logic                    v5;
  logic signed [YAW_W-1:0] y5;
  mix4_t                   m5;
  mix4_t                   s5;

  always_ff @(posedge clk) begin
    if (en) begin
      y5 <= y4;
      m5 <= m4;
      s5 <= sum_c5;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: highest motor with yaw
  logic                    v6;
  logic signed [YAW_W-1:0] y6;
  mix4_t                   m6;
  mix_t                    tot6;

  always_ff @(posedge clk) begin
    if (en) begin
      y6   <= y5;
      m6   <= m5;
      tot6 <= max2(max2(s5[0], s5[1]), max2(s5[2], s5[3]));
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: yaw excess, divider operands
  logic [A_W-1:0] a_c7;
  mix_t           diff_c7;
  logic           over_c7;

  always_comb begin
    a_c7    = y6[YAW_W-1] ? A_W'(-y6) : A_W'(y6);
    over_c7 = tot6 > mx_mix;
    diff_c7 = mix_t'(a_c7) + mx_mix - tot6;
  end

  logic           v7;
  logic [A_W-1:0] a7;
  logic [A_W-1:0] num7;
  div_side_t      side7;

  always_ff @(posedge clk) begin
    if (en) begin
      a7           <= a_c7;
      num7         <= diff_c7[A_W-1:0];
      side7.mix    <= m6;
      side7.yaw    <= y6;
      side7.over   <= over_c7;
      side7.do_div <= over_c7 && (a_c7 > A_W'(YAW_EPS)) && (diff_c7 > mix_t'(0));
    end
  end

  // ---------------------------------------------------------------------
  // Yaw scale division
  logic                 dv_valid;
  logic [FRAC_BITS-1:0] dv_quot;
  div_side_t            dv_side;

  qxm_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v7),
    .num       (num7),
    .den       (a7),
    .in_side   (side7),
    .out_valid (dv_valid),
    .quot      (dv_quot),
    .out_side  (dv_side)
  );

  // ---------------------------------------------------------------------
  // Stage M: pick scale, multiply yaw by it
  logic [SCALE_W-1:0]      scale_c;
  logic signed [SCALE_W:0] scale_s;

  always_comb begin
    if (!dv_side.over) begin
      scale_c = SCALE_W'(ONE_Q);
    end else if (dv_side.do_div) begin
      scale_c = {1'b0, dv_quot};
    end else begin
      scale_c = '0;
    end
    scale_s = {1'b0, scale_c};
  end

  logic                   vm;
  logic signed [SP_W-1:0] prod_m;
  mix4_t                  mm;
  logic                   lim_m;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_m <= dv_side.yaw * scale_s;
      mm     <= dv_side.mix;
      lim_m  <= dv_side.over;
    end
  end

  // ---------------------------------------------------------------------
  // Stage F: truncate scaled yaw toward zero, add to each motor
  logic signed [SP_W-1:0] prod_adj;
  logic signed [YS_W-1:0] ys_c;
  mix4_t                  v_cf;

  always_comb begin
    prod_adj = prod_m + (prod_m[SP_W-1] ? SP_W'(ONE_Q - 1) : SP_W'(0));
    ys_c     = prod_adj[SP_W-1:FRAC_BITS];
    for (int i = 0; i < 4; i++) begin
      v_cf[i] = mm[i] + (YAW_NEG[i] ? -mix_t'(ys_c) : mix_t'(ys_c));
    end
  end

  logic  vf;
  mix4_t mf;
  logic  lim_f;

  always_ff @(posedge clk) begin
    if (en) begin
      mf    <= v_cf;
      lim_f <= lim_m;
    end
  end

  // ---------------------------------------------------------------------
  // Stage C: clamp to idle..max
  logic [CFG_W-1:0]            idle_c;
  mix_t                        idle_mix;
  logic [3:0][MOT_W-1:0]       motor_cc;

  always_comb begin
    idle_c   = (idle_throttle > max_throttle) ? max_throttle : idle_throttle;
    idle_mix = mix_t'({1'b0, idle_c});
    for (int i = 0; i < 4; i++) begin
      if (mf[i] < idle_mix) begin
        motor_cc[i] = idle_c;
      end else if (mf[i] > mx_mix) begin
        motor_cc[i] = max_throttle;
      end else begin
        motor_cc[i] = mf[i][MOT_W-1:0];
      end
    end
  end

  logic                  fin_valid;
  logic [3:0][MOT_W-1:0] fin_motor;
  logic                  fin_lim;

  always_ff @(posedge clk) begin
    if (en) begin
      fin_motor <= motor_cc;
      fin_lim   <= lim_f;
    end
  end

  // ---------------------------------------------------------------------
  // Valid bits of the mix and output stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      vm        <= 1'b0;
      vf        <= 1'b0;
      fin_valid <= 1'b0;
    end else if (en) begin
      v1        <= s_axis_tvalid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      v6        <= v5;
      v7        <= v6;
      vm        <= dv_valid;
      vf        <= vm;
      fin_valid <= vf;
    end
  end

  // ---------------------------------------------------------------------
  // Output register with skid
  logic                  out_valid;
  logic [3:0][MOT_W-1:0] out_motor;
  logic                  out_lim;
  logic [3:0][MOT_W-1:0] skid_motor;
  logic                  skid_lim;
  logic                  out_free;

  assign out_free = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_free) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (fin_valid) begin
        if (out_free) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) begin
        out_motor <= skid_motor;
        out_lim   <= skid_lim;
      end
    end else if (fin_valid) begin
      if (out_free) begin
        out_motor <= fin_motor;
        out_lim   <= fin_lim;
      end else begin
        skid_motor <= fin_motor;
        skid_lim   <= fin_lim;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_motor};
  assign m_axis_tuser  = out_lim;

endmodule

`default_nettype wire
